FILE: sv/bmp24_pkg.sv
// Shared types and constants for the 24-bit BMP stream reader.
// No dependencies; used by bmp24_parser, bmp24_skid and bmp24_stream_reader.
package bmp24_pkg;

    // Size bounds accepted from the info header
    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    // Signature bytes
    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    // Header byte offsets
    localparam logic [5:0] HDR_SIG0     = 6'd0;
    localparam logic [5:0] HDR_SIG1     = 6'd1;
    localparam logic [5:0] HDR_WIDTH0   = 6'd18;
    localparam logic [5:0] HDR_WIDTH1   = 6'd19;
    localparam logic [5:0] HDR_WIDTH2   = 6'd20;
    localparam logic [5:0] HDR_WIDTH3   = 6'd21;
    localparam logic [5:0] HDR_HEIGHT0  = 6'd22;
    localparam logic [5:0] HDR_HEIGHT1  = 6'd23;
    localparam logic [5:0] HDR_HEIGHT2  = 6'd24;
    localparam logic [5:0] HDR_HEIGHT3  = 6'd25;
    localparam logic [5:0] HDR_LAST     = 6'd53;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_BADSIG  = 2'd2,
        KIND_BADSIZE = 2'd3
    } t_kind;

    // Parse phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_PIXEL  = 3'b010,
        PH_IDLE   = 3'b100
    } t_phase;

    // Pixel channel position within a triple
    typedef enum logic [1:0] {
        CH_BLUE  = 2'd0,
        CH_GREEN = 2'd1,
        CH_RED   = 2'd2
    } t_chan;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last;
    } t_result;

endpackage

FILE: sv/bmp24_parser.sv
// Header and pixel parser: one byte per request, one optional result per byte.
// Depends on bmp24_pkg.
module bmp24_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    output logic                o_res_valid,
    output bmp24_pkg::t_result  o_res
);

    bmp24_pkg::t_phase r_phase, n_phase;
    logic [5:0]        r_hcount, n_hcount;
    logic [31:0]       r_width, n_width;
    logic [31:0]       r_height, n_height;
    logic [11:0]       r_col, n_col;
    logic [11:0]       r_row, n_row;
    bmp24_pkg::t_chan  r_chan, n_chan;
    logic [15:0]       r_held, n_held;
    logic [1:0]        r_pad, n_pad;

    bmp24_pkg::t_phase  w_phase;
    logic [5:0]         w_hcount;
    logic [12:0]        w_col_inc;
    logic [12:0]        w_row_inc;
    logic               w_bad_size;

    // Start of file overrides the parse state for this byte
    assign w_phase   = i_start ? bmp24_pkg::PH_HEADER : r_phase;
    assign w_hcount  = i_start ? 6'd0 : r_hcount;
    assign w_col_inc = {1'b0, r_col} + 13'd1;
    assign w_row_inc = {1'b0, r_row} + 13'd1;
    assign w_bad_size = r_width[31] || r_height[31]
                     || (r_width > 32'(bmp24_pkg::MAX_WIDTH))
                     || (r_height > 32'(bmp24_pkg::MAX_HEIGHT));

    // Next state and result for the byte on the input
    always_comb begin
        n_phase  = w_phase;
        n_hcount = w_hcount;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_chan   = r_chan;
        n_held   = r_held;
        n_pad    = r_pad;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = bmp24_pkg::KIND_PIXEL;

        unique case (w_phase)
            bmp24_pkg::PH_HEADER: begin
                n_hcount = w_hcount + 6'd1;
                // size fields, little-endian
                case (w_hcount)
                    bmp24_pkg::HDR_WIDTH0:  n_width[7:0]    = i_byte;
                    bmp24_pkg::HDR_WIDTH1:  n_width[15:8]   = i_byte;
                    bmp24_pkg::HDR_WIDTH2:  n_width[23:16]  = i_byte;
                    bmp24_pkg::HDR_WIDTH3:  n_width[31:24]  = i_byte;
                    bmp24_pkg::HDR_HEIGHT0: n_height[7:0]   = i_byte;
                    bmp24_pkg::HDR_HEIGHT1: n_height[15:8]  = i_byte;
                    bmp24_pkg::HDR_HEIGHT2: n_height[23:16] = i_byte;
                    bmp24_pkg::HDR_HEIGHT3: n_height[31:24] = i_byte;
                    default: ;
                endcase
                if (((w_hcount == bmp24_pkg::HDR_SIG0) && (i_byte != bmp24_pkg::SIG_B))
                 || ((w_hcount == bmp24_pkg::HDR_SIG1) && (i_byte != bmp24_pkg::SIG_M))) begin
                    n_phase     = bmp24_pkg::PH_IDLE;
                    o_res_valid = 1'b1;
                    o_res.kind  = bmp24_pkg::KIND_BADSIG;
                end else if (w_hcount == bmp24_pkg::HDR_LAST) begin
                    o_res_valid = 1'b1;
                    if (w_bad_size) begin
                        n_phase    = bmp24_pkg::PH_IDLE;
                        o_res.kind = bmp24_pkg::KIND_BADSIZE;
                    end else begin
                        o_res.kind         = bmp24_pkg::KIND_HEADER;
                        o_res.image_width  = r_width[12:0];
                        o_res.image_height = r_height[12:0];
                        if ((r_width == 32'd0) || (r_height == 32'd0)) begin
                            n_phase    = bmp24_pkg::PH_IDLE;
                            o_res.last = 1'b1;
                        end else begin
                            n_phase = bmp24_pkg::PH_PIXEL;
                            n_col   = '0;
                            n_row   = '0;
                            n_chan  = bmp24_pkg::CH_BLUE;
                            n_pad   = '0;
                        end
                    end
                end
            end
            bmp24_pkg::PH_PIXEL: begin
                if (r_pad != 2'd0) begin
                    n_pad = r_pad - 2'd1;
                end else begin
                    case (r_chan)
                        bmp24_pkg::CH_BLUE: begin
                            n_held[7:0] = i_byte;
                            n_chan      = bmp24_pkg::CH_GREEN;
                        end
                        bmp24_pkg::CH_GREEN: begin
                            n_held[15:8] = i_byte;
                            n_chan       = bmp24_pkg::CH_RED;
                        end
                        default: begin
                            // red byte completes the pixel
                            n_chan             = bmp24_pkg::CH_BLUE;
                            o_res_valid        = 1'b1;
                            o_res.kind         = bmp24_pkg::KIND_PIXEL;
                            o_res.red          = i_byte;
                            o_res.green        = r_held[15:8];
                            o_res.blue         = r_held[7:0];
                            o_res.column       = r_col;
                            o_res.row          = r_row;
                            o_res.image_width  = r_width[12:0];
                            o_res.image_height = r_height[12:0];
                            n_col              = w_col_inc[11:0];
                            if (w_col_inc >= r_width[12:0]) begin
                                n_col = '0;
                                n_row = w_row_inc[11:0];
                                n_pad = r_width[1:0];
                                if (w_row_inc >= r_height[12:0]) begin
                                    o_res.last = 1'b1;
                                    n_phase    = bmp24_pkg::PH_IDLE;
                                end
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase

        if (!i_valid) begin
            o_res_valid = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bmp24_pkg::PH_HEADER;
            r_hcount <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_chan   <= bmp24_pkg::CH_BLUE;
            r_held   <= '0;
            r_pad    <= '0;
        end else if (i_valid) begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_chan   <= n_chan;
            r_held   <= n_held;
            r_pad    <= n_pad;
        end
    end

    // Pixel phase only with an accepted, non-empty size
    a_pixel_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == bmp24_pkg::PH_PIXEL) |->
            (r_width != 32'd0) && (r_width <= 32'(bmp24_pkg::MAX_WIDTH))
         && (r_height != 32'd0) && (r_height <= 32'(bmp24_pkg::MAX_HEIGHT)))
        else $error("pixel phase with out-of-range size");

    // Counters stay inside the image
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == bmp24_pkg::PH_PIXEL) |->
            ({1'b0, r_col} < r_width[12:0]) && ({1'b0, r_row} < r_height[12:0]))
        else $error("pixel position beyond image");

    // Header count never passes the last header byte while parsing it
    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == bmp24_pkg::PH_HEADER) |-> (r_hcount <= bmp24_pkg::HDR_LAST))
        else $error("header byte count overran");

endmodule

FILE: sv/bmp24_skid.sv
// Output register and skid stage, so input requests flow while one result waits.
// Depends on bmp24_pkg.
module bmp24_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bmp24_pkg::t_result  i_data,
    output logic                o_ready,
    output logic                o_valid,
    output bmp24_pkg::t_result  o_data,
    input  logic                i_ready
);

    logic               r_out_v;
    logic               r_skid_v;
    bmp24_pkg::t_result r_out;
    bmp24_pkg::t_result r_skid;

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // Control: output register refills from skid first, then from input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_ready) begin
            r_out_v  <= r_skid_v || i_valid;
            r_skid_v <= 1'b0;
        end else if (i_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_ready) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (i_valid && !r_skid_v) begin
            r_skid <= i_data;
        end
    end

    // Skid only holds a result behind a waiting output
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid full with output empty");

endmodule

FILE: sv/bmp24_stream_reader.sv
// Top level of the 24-bit BMP stream reader: stream ports and packing.
// Depends on bmp24_pkg, bmp24_parser and bmp24_skid.
//
// Usage:
//   Slave side takes the file one byte per request: tdata[7:0] is the byte,
//   tuser high marks the first byte of a new file and restarts the parse.
//   Master side gives at most one result per input byte: pixels (red, green,
//   blue with column and row, bottom row first), a header-accepted result on
//   header byte 53, or error results for a bad signature or a bad size.
//   tlast marks the final pixel, or the header result of an empty image.
// Timing:
//   One byte per clock sustained while o_s_tready is high. A result is registered
//   in the output register, or in the skid entry while the output waits; the parse
//   step sits between the parser state registers and the output register.
// Reset:
//   i_rst_n low clears the parse to header byte 0 and empties the output.
// Stall:
//   A two-entry output (register plus skid) keeps o_s_tready high while one
//   result waits; tready drops only when both entries are full.
module bmp24_stream_reader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] start_of_file
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [35:24] column, [47:36] row,
    // [60:48] image_width, [73:61] image_height, [79:74] zero
    output logic [79:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast
);

    logic               w_accept;
    logic               w_res_valid;
    bmp24_pkg::t_result w_res;
    bmp24_pkg::t_result w_out;

    assign w_accept = i_s_tvalid && o_s_tready;

    bmp24_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_byte      (i_s_tdata),
        .i_start     (i_s_tuser),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    bmp24_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_data  (w_res),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_tready)
    );

    // Pack result fields, lowest first
    assign o_m_tdata = {6'd0, w_out.image_height, w_out.image_width, w_out.row,
                        w_out.column, w_out.blue, w_out.green, w_out.red};
    assign o_m_tuser = w_out.kind;
    assign o_m_tlast = w_out.last;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for bmp24_stream_reader: directed BMP files from a table, then
// random files, broken files and noise, checked against a parse predictor or the table.
// Depends on bmp24_pkg and the bmp24_stream_reader RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 3_000_000;
    localparam int          RAND_BYTES   = 500;
    localparam int          QUIET_BYTES  = 380;
    localparam logic [15:0] WHOLE_FILE   = 16'hFFFF;
    localparam int          N_CASES      = 22;

    // Pixel fill patterns for generated files
    localparam logic [1:0]  FILL_RANDOM  = 2'd0;
    localparam logic [1:0]  FILL_ZERO    = 2'd1;
    localparam logic [1:0]  FILL_ONES    = 2'd2;
    localparam logic [1:0]  FILL_CHECKER = 2'd3;

    // One directed file: header content, how it is sent, and the typed header-level result
    typedef struct packed {
        logic [7:0]       sig0;
        logic [7:0]       sig1;
        logic [31:0]      width;
        logic [31:0]      height;
        logic             sof;
        logic [1:0]       fill;
        logic [15:0]      cut;
        logic [7:0]       tail;
        logic             typed;
        bmp24_pkg::t_kind kind;
        logic [12:0]      ew;
        logic [12:0]      eh;
        logic             elast;
    } t_file_case;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] data_byte
    logic        i_s_tuser  = 1'b0;    // [0] start_of_file
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b1;
    // [7:0] red, [15:8] green, [23:16] blue, [35:24] column, [47:36] row,
    // [60:48] image_width, [73:61] image_height, [79:74] zero
    logic [79:0] o_m_tdata;
    logic [1:0]  o_m_tuser;            // [1:0] kind
    logic        o_m_tlast;

    bmp24_stream_reader u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Predictor state
    bmp24_pkg::t_phase prs_phase;
    logic [5:0]        hdr_idx;
    logic [31:0]       w_raw;
    logic [31:0]       h_raw;
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    bmp24_pkg::t_chan  chan;
    logic [15:0]       bg_hold;
    logic [1:0]        pad_cnt;

    // Expected results and bookkeeping
    bmp24_pkg::t_result pending_results [$];
    logic [7:0]         file_q [$];
    t_file_case         dir_cases [0:N_CASES-1];
    bit                 typed_armed;
    bmp24_pkg::t_result typed_res;
    bit                 quiet;
    bit                 calm;
    int                 errors;
    int                 cycles;
    int                 n_bytes;
    int                 n_files;
    int                 n_kind [4];
    int unsigned        stall_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    // Parse state after reset or a start of file
    function automatic void parse_reset();
        prs_phase = bmp24_pkg::PH_HEADER;
        hdr_idx   = '0;
        w_raw     = '0;
        h_raw     = '0;
        col_cnt   = 0;
        row_cnt   = 0;
        chan      = bmp24_pkg::CH_BLUE;
        bg_hold   = '0;
        pad_cnt   = '0;
    endfunction

    // Advance the parse by one byte; returns 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] b, input logic sof,
                                      output bmp24_pkg::t_result r);
        logic [5:0] n;
        r = '0;
        if (sof)
            parse_reset();
        case (prs_phase)
            bmp24_pkg::PH_HEADER: begin
                n       = hdr_idx;
                hdr_idx = n + 6'd1;
                if ((n == bmp24_pkg::HDR_SIG0 && b != bmp24_pkg::SIG_B)
                 || (n == bmp24_pkg::HDR_SIG1 && b != bmp24_pkg::SIG_M)) begin
                    prs_phase = bmp24_pkg::PH_IDLE;
                    r.kind    = bmp24_pkg::KIND_BADSIG;
                    return 1'b1;
                end
                if (n >= bmp24_pkg::HDR_WIDTH0 && n <= bmp24_pkg::HDR_WIDTH3)
                    w_raw[(n - bmp24_pkg::HDR_WIDTH0) * 8 +: 8] = b;
                else if (n >= bmp24_pkg::HDR_HEIGHT0 && n <= bmp24_pkg::HDR_HEIGHT3)
                    h_raw[(n - bmp24_pkg::HDR_HEIGHT0) * 8 +: 8] = b;
                if (n == bmp24_pkg::HDR_LAST) begin
                    if (w_raw[31] || h_raw[31] || w_raw > bmp24_pkg::MAX_WIDTH
                     || h_raw > bmp24_pkg::MAX_HEIGHT) begin
                        prs_phase = bmp24_pkg::PH_IDLE;
                        r.kind    = bmp24_pkg::KIND_BADSIZE;
                        return 1'b1;
                    end
                    r.kind         = bmp24_pkg::KIND_HEADER;
                    r.image_width  = w_raw[12:0];
                    r.image_height = h_raw[12:0];
                    if (w_raw == 0 || h_raw == 0) begin
                        // empty image: header closes the file
                        prs_phase = bmp24_pkg::PH_IDLE;
                        r.last    = 1'b1;
                    end else begin
                        prs_phase = bmp24_pkg::PH_PIXEL;
                        col_cnt   = 0;
                        row_cnt   = 0;
                        chan      = bmp24_pkg::CH_BLUE;
                        pad_cnt   = '0;
                    end
                    return 1'b1;
                end
                return 1'b0;
            end
            bmp24_pkg::PH_PIXEL: begin
                if (pad_cnt != 0) begin
                    pad_cnt = pad_cnt - 2'd1;
                    return 1'b0;
                end
                if (chan == bmp24_pkg::CH_BLUE) begin
                    bg_hold = {8'h00, b};
                    chan    = bmp24_pkg::CH_GREEN;
                    return 1'b0;
                end
                if (chan == bmp24_pkg::CH_GREEN) begin
                    bg_hold[15:8] = b;
                    chan          = bmp24_pkg::CH_RED;
                    return 1'b0;
                end
                r.kind         = bmp24_pkg::KIND_PIXEL;
                r.red          = b;
                r.green        = bg_hold[15:8];
                r.blue         = bg_hold[7:0];
                r.column       = col_cnt[11:0];
                r.row          = row_cnt[11:0];
                r.image_width  = w_raw[12:0];
                r.image_height = h_raw[12:0];
                chan           = bmp24_pkg::CH_BLUE;
                col_cnt        = col_cnt + 1;
                // end of row: padding follows, and maybe the end of the image
                if (col_cnt >= w_raw) begin
                    col_cnt = 0;
                    row_cnt = row_cnt + 1;
                    pad_cnt = w_raw[1:0];
                    if (row_cnt >= h_raw) begin
                        r.last    = 1'b1;
                        prs_phase = bmp24_pkg::PH_IDLE;
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Send one byte request, wait for acceptance, then record what it should cause
    task automatic send_byte(input logic [7:0] b, input logic sof);
        bmp24_pkg::t_result r;
        if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= sof;
        do @(posedge i_clk); while (!o_s_tready);
        n_bytes++;
        if (parse_byte(b, sof, r)) begin
            if (typed_armed && r.kind != bmp24_pkg::KIND_PIXEL) begin
                pending_results.push_back(typed_res);
                typed_armed = 1'b0;
            end else begin
                pending_results.push_back(r);
            end
        end
    endtask

    // Lay out a file: 54 header bytes, then pixel rows with padding where the size is sane
    task automatic build_file(input logic [7:0] s0, input logic [7:0] s1,
                              input logic [31:0] w, input logic [31:0] h,
                              input logic [1:0] fill);
        int unsigned nbytes;
        logic [7:0]  px;
        file_q.delete();
        for (int i = 0; i < 54; i++) begin
            if (i == bmp24_pkg::HDR_SIG0)
                file_q.push_back(s0);
            else if (i == bmp24_pkg::HDR_SIG1)
                file_q.push_back(s1);
            else if (i >= bmp24_pkg::HDR_WIDTH0 && i <= bmp24_pkg::HDR_WIDTH3)
                file_q.push_back(w[(i - bmp24_pkg::HDR_WIDTH0) * 8 +: 8]);
            else if (i >= bmp24_pkg::HDR_HEIGHT0 && i <= bmp24_pkg::HDR_HEIGHT3)
                file_q.push_back(h[(i - bmp24_pkg::HDR_HEIGHT0) * 8 +: 8]);
            else
                file_q.push_back(8'($urandom_range(0, 255)));
        end
        if (w >= 1 && w <= bmp24_pkg::MAX_WIDTH && h >= 1 && h <= bmp24_pkg::MAX_HEIGHT)
            nbytes = h * (3 * w + (w & 3));
        else
            nbytes = $urandom_range(0, 8);
        for (int unsigned i = 0; i < nbytes; i++) begin
            case (fill)
                FILL_ZERO:    px = 8'h00;
                FILL_ONES:    px = 8'hFF;
                FILL_CHECKER: px = i[0] ? 8'hAA : 8'h55;
                default:      px = 8'($urandom_range(0, 255));
            endcase
            file_q.push_back(px);
        end
    endtask

    // Send the built file, possibly cut short, followed by trailing bytes
    task automatic send_file(input logic sof0, input int cut, input int tail);
        int nsend;
        nsend = (cut < 0 || cut > file_q.size()) ? file_q.size() : cut;
        for (int i = 0; i < nsend; i++)
            send_byte(file_q[i], (i == 0) ? sof0 : 1'b0);
        for (int i = 0; i < tail; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        n_files++;
    endtask

    // Stop sending until every outstanding result has come out
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string nm, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%t: %s mismatch, expected %0h, actual %0h", $realtime, nm, want, got);
            errors++;
        end
    endtask

    // Receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet || calm) begin
            i_m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= (stall_left == 1);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 15);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        bmp24_pkg::t_result e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%t: unexpected result, kind %0d data %0h last %0b",
                         $realtime, o_m_tuser, o_m_tdata, o_m_tlast);
                errors++;
            end else begin
                e = pending_results.pop_front();
                n_kind[e.kind]++;
                check_field("kind",         e.kind,         o_m_tuser);
                check_field("red",          e.red,          o_m_tdata[7:0]);
                check_field("green",        e.green,        o_m_tdata[15:8]);
                check_field("blue",         e.blue,         o_m_tdata[23:16]);
                check_field("column",       e.column,       o_m_tdata[35:24]);
                check_field("row",          e.row,          o_m_tdata[47:36]);
                check_field("image_width",  e.image_width,  o_m_tdata[60:48]);
                check_field("image_height", e.image_height, o_m_tdata[73:61]);
                check_field("zero fill",    6'd0,           o_m_tdata[79:74]);
                check_field("last",         e.last,         o_m_tlast);
            end
        end
    end

    // Stimulus
    initial begin
        int          rand_bytes;
        int          pick;
        int          cut;
        logic        sof0;
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [31:0] w;
        logic [31:0] h;
        t_file_case  fc;

        errors      = 0;
        cycles      = 0;
        n_bytes     = 0;
        n_files     = 0;
        n_kind      = '{default: 0};
        quiet       = 1'b0;
        calm        = 1'b0;
        typed_armed = 1'b0;
        stall_left  = 0;
        parse_reset();

        // sig0 sig1 width height / sof fill cut tail / typed kind ew eh last
        dir_cases = '{
            // stream parsed from reset without a start flag
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd2, 32'd2,
              1'b0, FILL_RANDOM, WHOLE_FILE, 8'd0,
              1'b1, bmp24_pkg::KIND_HEADER, 13'd2, 13'd2, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd1, 32'd1,
              1'b1, FILL_ONES, WHOLE_FILE, 8'd0,
              1'b1, bmp24_pkg::KIND_HEADER, 13'd1, 13'd1, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd3, 32'd2,
              1'b1, FILL_ONES, WHOLE_FILE, 8'd0,
              1'b0, bmp24_pkg::KIND_HEADER, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd5, 32'd3,
              1'b1, FILL_ZERO, WHOLE_FILE, 8'd0,
              1'b0, bmp24_pkg::KIND_HEADER, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd4, 32'd2,
              1'b1, FILL_CHECKER, WHOLE_FILE, 8'd2,
              1'b0, bmp24_pkg::KIND_HEADER, 13'd0, 13'd0, 1'b0},
            // empty images, trailing bytes ignored
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd0, 32'd5,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd10,
              1'b1, bmp24_pkg::KIND_HEADER, 13'd0, 13'd5, 1'b1},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd7, 32'd0,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd4,
              1'b1, bmp24_pkg::KIND_HEADER, 13'd7, 13'd0, 1'b1},
            // bad signatures
            '{8'h41, bmp24_pkg::SIG_M, 32'd2, 32'd2,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd3,
              1'b1, bmp24_pkg::KIND_BADSIG, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, 8'h4E, 32'd2, 32'd2,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd0,
              1'b1, bmp24_pkg::KIND_BADSIG, 13'd0, 13'd0, 1'b0},
            '{8'hFF, 8'h00, 32'd2, 32'd2,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd0,
              1'b1, bmp24_pkg::KIND_BADSIG, 13'd0, 13'd0, 1'b0},
            // sizes out of range, including negative ones
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd4097, 32'd1,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd0,
              1'b1, bmp24_pkg::KIND_BADSIZE, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd1, 32'd4097,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd0,
              1'b1, bmp24_pkg::KIND_BADSIZE, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'h8000_0001, 32'd1,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd0,
              1'b1, bmp24_pkg::KIND_BADSIZE, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd1, 32'hFFFF_FFFF,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd0,
              1'b1, bmp24_pkg::KIND_BADSIZE, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'h0001_0000, 32'd2,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd0,
              1'b1, bmp24_pkg::KIND_BADSIZE, 13'd0, 13'd0, 1'b0},
            // largest sizes, pixel data cut after a few pixels
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd4096, 32'd1,
              1'b1, FILL_RANDOM, 16'd66, 8'd0,
              1'b1, bmp24_pkg::KIND_HEADER, 13'd4096, 13'd1, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd1, 32'd4096,
              1'b1, FILL_RANDOM, 16'd66, 8'd0,
              1'b1, bmp24_pkg::KIND_HEADER, 13'd1, 13'd4096, 1'b0},
            // cut in the pixels, then cut in the header: next start lands mid-file
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd3, 32'd3,
              1'b1, FILL_RANDOM, 16'd70, 8'd0,
              1'b0, bmp24_pkg::KIND_HEADER, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd2, 32'd2,
              1'b1, FILL_RANDOM, 16'd20, 8'd0,
              1'b0, bmp24_pkg::KIND_HEADER, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd6, 32'd2,
              1'b1, FILL_RANDOM, WHOLE_FILE, 8'd5,
              1'b0, bmp24_pkg::KIND_HEADER, 13'd0, 13'd0, 1'b0},
            // whole file after a finished one without a start flag: all ignored
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd2, 32'd2,
              1'b0, FILL_RANDOM, WHOLE_FILE, 8'd0,
              1'b0, bmp24_pkg::KIND_HEADER, 13'd0, 13'd0, 1'b0},
            '{bmp24_pkg::SIG_B, bmp24_pkg::SIG_M, 32'd2, 32'd1,
              1'b1, FILL_ZERO, WHOLE_FILE, 8'd0,
              1'b0, bmp24_pkg::KIND_HEADER, 13'd0, 13'd0, 1'b0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed files
        for (int k = 0; k < N_CASES; k++) begin
            fc = dir_cases[k];
            typed_res              = '0;
            typed_res.kind         = fc.kind;
            typed_res.image_width  = fc.ew;
            typed_res.image_height = fc.eh;
            typed_res.last         = fc.elast;
            typed_armed            = fc.typed;
            build_file(fc.sig0, fc.sig1, fc.width, fc.height, fc.fill);
            send_file(fc.sof, (fc.cut == WHOLE_FILE) ? -1 : int'(fc.cut), int'(fc.tail));
            typed_armed = 1'b0;
        end
        drain_results();

        // Random files: mostly well formed, the rest broken or noise
        rand_bytes = 0;
        while (rand_bytes < RAND_BYTES) begin
            calm  = ($urandom_range(0, 4) == 0);
            quiet = (rand_bytes >= QUIET_BYTES);
            if ($urandom_range(0, 9) == 0)
                drain_results();
            pick = $urandom_range(0, 99);
            s0   = bmp24_pkg::SIG_B;
            s1   = bmp24_pkg::SIG_M;
            sof0 = ($urandom_range(0, 19) != 0);
            cut  = -1;
            w    = $urandom_range(1, 9);
            h    = $urandom_range(1, 5);
            if (pick < 5) begin
                w = $urandom_range(10, 64);
                h = $urandom_range(1, 2);
            end else if (pick >= 80 && pick < 88) begin
                w = $urandom();
                h = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 8192);
                if (w <= bmp24_pkg::MAX_WIDTH && h <= bmp24_pkg::MAX_HEIGHT)
                    w[31] = 1'b1;
            end else if (pick >= 88 && pick < 94) begin
                s0 = 8'($urandom_range(0, 255));
                s1 = 8'($urandom_range(0, 255));
                if (s0 == bmp24_pkg::SIG_B && s1 == bmp24_pkg::SIG_M)
                    s1 = ~bmp24_pkg::SIG_M;
            end else if (pick >= 94 && pick < 97) begin
                if ($urandom_range(0, 1) != 0)
                    w = 0;
                else
                    h = 0;
            end
            if (pick >= 97) begin
                // noise with the odd start flag
                for (int i = $urandom_range(1, 30); i > 0; i--) begin
                    send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                    rand_bytes++;
                end
            end else begin
                build_file(s0, s1, w, h, FILL_RANDOM);
                if (pick >= 70 && pick < 80)
                    cut = int'($urandom_range(1, file_q.size() - 1));
                send_file(sof0, cut, int'($urandom_range(0, 3)));
                rand_bytes += (cut < 0) ? file_q.size() : cut;
            end
        end

        quiet = 1'b1;
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("tb: %0d files, %0d bytes taken in %0d cycles", n_files, n_bytes, cycles);
        $display("tb: results %0d pixel, %0d header, %0d bad signature, %0d bad size",
                 n_kind[bmp24_pkg::KIND_PIXEL], n_kind[bmp24_pkg::KIND_HEADER],
                 n_kind[bmp24_pkg::KIND_BADSIG], n_kind[bmp24_pkg::KIND_BADSIZE]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
